// ----- hdl/abrm_pkg.sv -----
// Shared constants for the allocation bitmap range marker.
package abrm_pkg;

    localparam int CONTAINER_BLOCKS_DEF = 65536;
    localparam int POOL_SIZE_DEF        = 4096;

    localparam int WORD_W    = 64;
    localparam int FIRST_W   = 48;
    localparam int TOTAL_W   = 32;
    localparam int CCOUNT_W  = 17;
    localparam int BASE_W    = 48;
    localparam int PCOUNT_W  = 13;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    // Sums of a block number and a length, one bit wider than a block number.
    localparam int SUM_W = FIRST_W + 1;
    // Pool offset plus length, one bit wider than a length.
    localparam int HI_W  = TOTAL_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_CONTAINER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT      = 2'd2;

endpackage

// ----- hdl/abrm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module abrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/allocation_bitmap_range_marker.sv -----
// Top level of the allocation bitmap range marker: sequencer, checks and bitmap walk.
//
// Each request word on the s_ channel names a bitmap (container or pool), a first
// block and a length. The block checks the range against the configured counts,
// sets every block of the accepted range in the chosen bitmap (a pool range is
// clipped to the pool end), and returns one result word on the m_ channel with
// the double-use, out-of-range and overrun flags. The configuration registers are
// written through cfg_we, cfg_index and cfg_wdata; the user must write them only
// while no request is in progress, as the block does not enforce it. A request is
// taken only while the sequencer is idle. A rejected or zero-length request goes
// through S_SUM and S_CHECK to S_DONE; a marked request passes through S_SUM,
// S_CHECK and S_BOUND, then S_WALK once per 64-bit bitmap word that the range
// touches, as the walk reads and rewrites one word a cycle through the bitmap RAM
// ports. The next request can be taken in the cycle after the result is loaded.
// After reset both bitmaps are cleared by a sweep of one word a cycle over the
// larger bitmap (1024 words at the default sizes); s_ready stays low until then.
// The result sits in an output register; if the receiver stalls, the next result
// waits in the sequencer until the register is free.
module allocation_bitmap_range_marker #(
    parameter int CONTAINER_BLOCKS = abrm_pkg::CONTAINER_BLOCKS_DEF,
    parameter int POOL_SIZE        = abrm_pkg::POOL_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_we,
    input  logic [abrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abrm_pkg::CFG_W-1:0]       cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [abrm_pkg::FIRST_W-1:0]     s_first_block,
    input  logic [abrm_pkg::TOTAL_W-1:0]     s_block_total,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_double_use,
    output logic                             m_out_of_range,
    output logic                             m_pool_overrun
);

    import abrm_pkg::*;

    localparam int CWORDS = (CONTAINER_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int PWORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
    localparam int CAW    = (CWORDS > 1) ? $clog2(CWORDS) : 1;
    localparam int PAW    = (PWORDS > 1) ? $clog2(PWORDS) : 1;
    localparam int WAW    = (CAW > PAW) ? CAW : PAW;
    localparam int WBW    = WAW + 6;
    localparam int CLR_WORDS = (CWORDS > PWORDS) ? CWORDS : PWORDS;

    localparam logic [WAW:0]       CWORDS_V  = (WAW+1)'(CWORDS);
    localparam logic [WAW:0]       PWORDS_V  = (WAW+1)'(PWORDS);
    localparam logic [WAW-1:0]     CLR_LAST  = WAW'(CLR_WORDS - 1);
    localparam logic [SUM_W-1:0]   CBLK_V    = SUM_W'(CONTAINER_BLOCKS);
    localparam logic [SUM_W-1:0]   PBLK_V    = SUM_W'(POOL_SIZE);
    localparam logic [WORD_W-1:0]  ALL_ONES  = {WORD_W{1'b1}};

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_BOUND = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [WAW-1:0]      ptr_reg, ptr_next;
    logic                type_reg, type_next;
    logic [FIRST_W-1:0]  first_reg, first_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    pend_reg, pend_next;
    logic [WBW-1:0]      lo_reg, lo_next;
    logic [WBW-1:0]      last_reg, last_next;
    logic                dup_reg, dup_next;
    logic                oor_reg, oor_next;
    logic                ovr_reg, ovr_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_double_use_reg, m_double_use_next;
    logic                m_out_of_range_reg, m_out_of_range_next;
    logic                m_pool_overrun_reg, m_pool_overrun_next;

    logic [CCOUNT_W-1:0] container_count_reg;
    logic [BASE_W-1:0]   pool_base_reg;
    logic [PCOUNT_W-1:0] pool_count_reg;

    logic [SUM_W-1:0]    lim;
    logic [SUM_W-1:0]    pcnt;
    logic [SUM_W-1:0]    first_ext;
    logic [SUM_W-1:0]    base_ext;
    logic                c_oor;
    logic                p_fin;
    logic                p_lin;
    logic [HI_W-1:0]     hi_raw;
    logic [HI_W-1:0]     hi_clip;
    logic [HI_W-1:0]     pcnt_hi;

    logic [WAW-1:0]      rd_word;
    logic [WORD_W-1:0]   c_rdata;
    logic [WORD_W-1:0]   p_rdata;
    logic [WORD_W-1:0]   cur_word;
    logic [5:0]          lb;
    logic [5:0]          ub;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   wdata;
    logic                c_we;
    logic                p_we;
    logic                load_out;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            container_count_reg <= '0;
            pool_base_reg       <= '0;
            pool_count_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CONTAINER_COUNT: container_count_reg <= cfg_wdata[CCOUNT_W-1:0];
                REG_POOL_BASE:       pool_base_reg       <= cfg_wdata[BASE_W-1:0];
                REG_POOL_COUNT:      pool_count_reg      <= cfg_wdata[PCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Limits clipped to the bitmap capacities.
    always_comb begin
        lim = (SUM_W'(container_count_reg) > CBLK_V) ? CBLK_V
                                                     : SUM_W'(container_count_reg);
        pcnt = (SUM_W'(pool_count_reg) > PBLK_V) ? PBLK_V : SUM_W'(pool_count_reg);
        pcnt_hi   = pcnt[HI_W-1:0];
        first_ext = SUM_W'(first_reg);
        base_ext  = SUM_W'(pool_base_reg);
        c_oor = sum_reg > lim;
        p_fin = (first_ext >= base_ext) && (first_ext < pend_reg);
        p_lin = (sum_reg > base_ext) && (sum_reg <= pend_reg);
        hi_raw  = HI_W'(lo_reg) + HI_W'(total_reg);
        hi_clip = (hi_raw > pcnt_hi) ? pcnt_hi : hi_raw;
    end

    // Word mask for the walk.
    always_comb begin
        cur_word = type_reg ? p_rdata : c_rdata;
        lb   = (ptr_reg == lo_reg[WBW-1:6])   ? lo_reg[5:0]   : 6'd0;
        ub   = (ptr_reg == last_reg[WBW-1:6]) ? last_reg[5:0] : 6'd63;
        mask = (ALL_ONES << lb) & (ALL_ONES >> (6'd63 - ub));
    end

    always_comb begin
        state_next          = state_reg;
        ptr_next            = ptr_reg;
        type_next           = type_reg;
        first_next          = first_reg;
        total_next          = total_reg;
        sum_next            = sum_reg;
        pend_next           = pend_reg;
        lo_next             = lo_reg;
        last_next           = last_reg;
        dup_next            = dup_reg;
        oor_next            = oor_reg;
        ovr_next            = ovr_reg;
        rd_word             = ptr_reg;
        wdata               = '0;
        c_we                = 1'b0;
        p_we                = 1'b0;
        load_out            = 1'b0;
        s_ready             = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                c_we = {1'b0, ptr_reg} < CWORDS_V;
                p_we = {1'b0, ptr_reg} < PWORDS_V;
                if (ptr_reg == CLR_LAST) begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    type_next  = s_req_type;
                    first_next = s_first_block;
                    total_next = s_block_total;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                sum_next   = SUM_W'(first_reg) + SUM_W'(total_reg);
                pend_next  = SUM_W'(pool_base_reg) + pcnt;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                dup_next = 1'b0;
                if (type_reg) begin
                    lo_next = first_reg[WBW-1:0] - pool_base_reg[WBW-1:0];
                end else begin
                    lo_next = first_reg[WBW-1:0];
                end
                if (total_reg == '0) begin
                    oor_next   = 1'b0;
                    ovr_next   = 1'b0;
                    state_next = S_DONE;
                end else if (!type_reg) begin
                    oor_next   = c_oor;
                    ovr_next   = 1'b0;
                    state_next = c_oor ? S_DONE : S_BOUND;
                end else begin
                    oor_next   = !p_fin;
                    ovr_next   = p_fin ^ p_lin;
                    state_next = p_fin ? S_BOUND : S_DONE;
                end
            end
            S_BOUND: begin
                if (type_reg) begin
                    last_next = WBW'(hi_clip - 1'b1);
                end else begin
                    last_next = sum_reg[WBW-1:0] - 1'b1;
                end
                rd_word    = lo_reg[WBW-1:6];
                ptr_next   = lo_reg[WBW-1:6];
                state_next = S_WALK;
            end
            S_WALK: begin
                wdata    = cur_word | mask;
                c_we     = !type_reg;
                p_we     = type_reg;
                dup_next = dup_reg | (|(cur_word & mask));
                rd_word  = ptr_reg + 1'b1;
                if (ptr_reg == last_reg[WBW-1:6]) begin
                    state_next = S_DONE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next        = (m_valid_reg && !m_ready) || load_out;
        m_double_use_next   = load_out ? dup_reg : m_double_use_reg;
        m_out_of_range_next = load_out ? oor_reg : m_out_of_range_reg;
        m_pool_overrun_next = load_out ? ovr_reg : m_pool_overrun_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg           <= type_next;
        first_reg          <= first_next;
        total_reg          <= total_next;
        sum_reg            <= sum_next;
        pend_reg           <= pend_next;
        lo_reg             <= lo_next;
        last_reg           <= last_next;
        dup_reg            <= dup_next;
        oor_reg            <= oor_next;
        ovr_reg            <= ovr_next;
        m_double_use_reg   <= m_double_use_next;
        m_out_of_range_reg <= m_out_of_range_next;
        m_pool_overrun_reg <= m_pool_overrun_next;
    end

    abrm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CWORDS)
    ) u_container_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (ptr_reg[CAW-1:0]),
        .wdata (wdata),
        .raddr (rd_word[CAW-1:0]),
        .rdata (c_rdata)
    );

    abrm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PWORDS)
    ) u_pool_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (ptr_reg[PAW-1:0]),
        .wdata (wdata),
        .raddr (rd_word[PAW-1:0]),
        .rdata (p_rdata)
    );

    assign m_valid        = m_valid_reg;
    assign m_double_use   = m_double_use_reg;
    assign m_out_of_range = m_out_of_range_reg;
    assign m_pool_overrun = m_pool_overrun_reg;

endmodule
